// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file rri_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is low
`define RRI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rri assertion failed");

// concurrent assertion that also holds during reset
`define RRI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("rri assertion failed");

`endif

// ===== rtl/rri_pkg.sv =====
// widths, register indexes and item types for the ray / parallelogram test
// no dependencies
`default_nettype none

package rri_pkg;

    localparam int CoordW   = 16;
    localparam int FracBits = 10;
    localparam int VecW     = 3 * CoordW;
    localparam int ThrW     = 16;
    localparam int DiffW    = CoordW + 1;
    localparam int PdW      = CoordW + DiffW;
    localparam int DotW     = PdW + 2;
    localparam int MagW     = DotW - 1;
    localparam int QuotBits = CoordW + 2;
    localparam int ProdW    = MagW + DiffW;
    localparam int RemW     = MagW + QuotBits + 1;
    localparam int CrossW   = 2 * CoordW + 1;
    localparam int DetPW    = CoordW + CrossW;
    localparam int EdgePW   = DiffW + CrossW;
    localparam int WideW    = EdgePW + 2;
    localparam int HitW     = CoordW + 3;

    localparam int QDepth   = 4;
    localparam int QAddrW   = 2;

    localparam int CfgIdxW  = 3;
    localparam int CfgW     = VecW;

    localparam logic [CfgIdxW-1:0] CfgCorner = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgEdgeU  = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgEdgeV  = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgNormal = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgThresh = 3'd4;

    // one classified ray handed from the front to the back
    typedef struct packed {
        logic [2:0][CoordW-1:0] s;
        logic [2:0][DiffW-1:0]  d;
        logic [MagW-1:0]        anum;
        logic [MagW-1:0]        aden;
        logic                   rej;
    } t_ray_item;

    typedef struct packed {
        logic      valid;
        t_ray_item item;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/ray_rectangle_intersect.sv =====
// ray / parallelogram intersection, one ray accepted per cycle, one result each
// 28 register stages: 3 front, queue, offset product, rounding, 18 divider,
// hit point, edge products, edge sums, edge test
// throughput: one ray per cycle while the result side keeps taking items
// synchronous active-low reset clears all valid state and restores the default configuration
`default_nettype none

module ray_rectangle_intersect (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tdata: ray_start_x, ray_start_y, ray_start_z, ray_end_x, ray_end_y, ray_end_z
    input  wire logic [6*rri_pkg::CoordW-1:0]  s_axis_tdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: hit_x, hit_y, hit_z
    output logic [rri_pkg::VecW-1:0]           m_axis_tdata,
    // tuser: hit
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          i_cfg_we,
    input  wire logic [rri_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [rri_pkg::CfgW-1:0]      i_cfg_data
);

    logic [rri_pkg::VecW-1:0] r_corner;
    logic [rri_pkg::VecW-1:0] r_edge_u;
    logic [rri_pkg::VecW-1:0] r_edge_v;
    logic [rri_pkg::VecW-1:0] r_normal;
    logic [rri_pkg::ThrW-1:0] r_thresh;

    // plane basis terms, registered from the configuration: cross products, then determinant products, then their sum
    logic signed [rri_pkg::CrossW-1:0] r_vn [3];
    logic signed [rri_pkg::CrossW-1:0] r_nu [3];
    logic signed [rri_pkg::DetPW-1:0]  r_detp [3];
    logic signed [rri_pkg::WideW-1:0]  r_det;

    logic signed [rri_pkg::CoordW-1:0]   u [3];
    logic signed [rri_pkg::CoordW-1:0]   v [3];
    logic signed [rri_pkg::CoordW-1:0]   n [3];
    logic [2:0][rri_pkg::CrossW-1:0]     vn_pk;
    logic [2:0][rri_pkg::CrossW-1:0]     nu_pk;

    rri_pkg::t_push push;
    rri_pkg::t_push head;
    logic           q_full;
    logic           take;
    logic           hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_edge_u <= '0;
            r_edge_v <= '0;
            r_normal <= '0;
            r_thresh <= rri_pkg::ThrW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rri_pkg::CfgCorner: r_corner <= i_cfg_data;
                rri_pkg::CfgEdgeU:  r_edge_u <= i_cfg_data;
                rri_pkg::CfgEdgeV:  r_edge_v <= i_cfg_data;
                rri_pkg::CfgNormal: r_normal <= i_cfg_data;
                rri_pkg::CfgThresh: r_thresh <= i_cfg_data[rri_pkg::ThrW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u[k] = $signed(r_edge_u[k*rri_pkg::CoordW +: rri_pkg::CoordW]);
            v[k] = $signed(r_edge_v[k*rri_pkg::CoordW +: rri_pkg::CoordW]);
            n[k] = $signed(r_normal[k*rri_pkg::CoordW +: rri_pkg::CoordW]);
            vn_pk[k] = r_vn[k];
            nu_pk[k] = r_nu[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_vn[0] <= rri_pkg::CrossW'(v[1] * n[2]) - rri_pkg::CrossW'(v[2] * n[1]);
        r_vn[1] <= rri_pkg::CrossW'(v[2] * n[0]) - rri_pkg::CrossW'(v[0] * n[2]);
        r_vn[2] <= rri_pkg::CrossW'(v[0] * n[1]) - rri_pkg::CrossW'(v[1] * n[0]);
        r_nu[0] <= rri_pkg::CrossW'(n[1] * u[2]) - rri_pkg::CrossW'(n[2] * u[1]);
        r_nu[1] <= rri_pkg::CrossW'(n[2] * u[0]) - rri_pkg::CrossW'(n[0] * u[2]);
        r_nu[2] <= rri_pkg::CrossW'(n[0] * u[1]) - rri_pkg::CrossW'(n[1] * u[0]);
        for (int k = 0; k < 3; k++) r_detp[k] <= u[k] * r_vn[k];
        r_det <= rri_pkg::WideW'(r_detp[0]) + rri_pkg::WideW'(r_detp[1])
               + rri_pkg::WideW'(r_detp[2]);
    end

    rri_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_corner (r_corner),
        .i_normal (r_normal),
        .i_thresh (r_thresh),
        .i_q_full (q_full),
        .o_push   (push)
    );

    rri_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (take),
        .o_head  (head)
    );

    rri_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_take   (take),
        .i_corner (r_corner),
        .i_vn     (vn_pk),
        .i_nu     (nu_pk),
        .i_det    (rri_pkg::WideW'(r_det)),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_hit    (hit),
        .o_point  (m_axis_tdata)
    );

    assign m_axis_tuser[0] = hit;

endmodule

`default_nettype wire

// ===== rtl/rri_front.sv =====
// front: accepts rays, forms direction, plane dot products and the early reject
// depends on rri_pkg
`default_nettype none

module rri_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [6*rri_pkg::CoordW-1:0] i_data,
    input  wire logic [rri_pkg::VecW-1:0]    i_corner,
    input  wire logic [rri_pkg::VecW-1:0]    i_normal,
    input  wire logic [rri_pkg::ThrW-1:0]    i_thresh,
    input  wire logic                        i_q_full,
    output rri_pkg::t_push                   o_push
);

    logic en;

    logic                              r_f1_v;
    logic signed [rri_pkg::CoordW-1:0] r_f1_s [3];
    logic signed [rri_pkg::DiffW-1:0]  r_f1_d [3];
    logic signed [rri_pkg::DiffW-1:0]  r_f1_e [3];

    logic                              r_f2_v;
    logic signed [rri_pkg::CoordW-1:0] r_f2_s [3];
    logic signed [rri_pkg::DiffW-1:0]  r_f2_d [3];
    logic signed [rri_pkg::PdW-1:0]    r_f2_pd [3];
    logic signed [rri_pkg::PdW-1:0]    r_f2_pn [3];

    logic                              r_f3_v;
    rri_pkg::t_ray_item                r_f3_item;

    logic signed [rri_pkg::CoordW-1:0] n_s [3];
    logic signed [rri_pkg::CoordW-1:0] n_e [3];
    logic signed [rri_pkg::CoordW-1:0] a_k [3];
    logic signed [rri_pkg::CoordW-1:0] nrm [3];
    logic signed [rri_pkg::DotW-1:0]   denom;
    logic signed [rri_pkg::DotW-1:0]   num;
    logic [rri_pkg::MagW-1:0]          aden;
    logic [rri_pkg::MagW-1:0]          anum;
    logic [rri_pkg::MagW-1:0]          thr_sh;
    rri_pkg::t_ray_item                n_item;

    assign en      = !(r_f3_v && i_q_full);
    assign o_ready = en;
    assign o_push  = '{valid: r_f3_v, item: r_f3_item};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s[k] = $signed(i_data[k*rri_pkg::CoordW +: rri_pkg::CoordW]);
            n_e[k] = $signed(i_data[(3+k)*rri_pkg::CoordW +: rri_pkg::CoordW]);
            a_k[k] = $signed(i_corner[k*rri_pkg::CoordW +: rri_pkg::CoordW]);
            nrm[k] = $signed(i_normal[k*rri_pkg::CoordW +: rri_pkg::CoordW]);
        end
    end

    // plane sums, magnitudes and the three early miss cases
    always_comb begin
        denom = rri_pkg::DotW'(r_f2_pd[0]) + rri_pkg::DotW'(r_f2_pd[1])
              + rri_pkg::DotW'(r_f2_pd[2]);
        num   = rri_pkg::DotW'(r_f2_pn[0]) + rri_pkg::DotW'(r_f2_pn[1])
              + rri_pkg::DotW'(r_f2_pn[2]);
        aden  = rri_pkg::MagW'(denom < 0 ? -denom : denom);
        anum  = rri_pkg::MagW'(num < 0 ? -num : num);
        thr_sh = rri_pkg::MagW'(i_thresh) << rri_pkg::FracBits;
        for (int k = 0; k < 3; k++) begin
            n_item.s[k] = r_f2_s[k];
            n_item.d[k] = r_f2_d[k];
        end
        n_item.anum = anum;
        n_item.aden = aden;
        n_item.rej  = (denom == '0) || (aden < thr_sh)
                   || ((num != '0) && ((num < 0) != (denom < 0)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= i_valid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_f1_s[k]  <= n_s[k];
                r_f1_d[k]  <= rri_pkg::DiffW'(n_e[k]) - rri_pkg::DiffW'(n_s[k]);
                r_f1_e[k]  <= rri_pkg::DiffW'(a_k[k]) - rri_pkg::DiffW'(n_s[k]);
                r_f2_s[k]  <= r_f1_s[k];
                r_f2_d[k]  <= r_f1_d[k];
                r_f2_pd[k] <= nrm[k] * r_f1_d[k];
                r_f2_pn[k] <= nrm[k] * r_f1_e[k];
            end
            r_f3_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rri_queue.sv =====
// short item queue between front and back
// depends on rri_pkg
`default_nettype none

module rri_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rri_pkg::t_push  i_push,
    output logic                 o_full,
    input  wire logic            i_pop,
    output rri_pkg::t_push       o_head
);

    rri_pkg::t_ray_item          r_mem [rri_pkg::QDepth];
    logic [rri_pkg::QAddrW-1:0]  r_wp;
    logic [rri_pkg::QAddrW-1:0]  r_rp;
    logic [rri_pkg::QAddrW:0]    r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_cnt == rri_pkg::QDepth);
    assign o_head  = '{valid: (r_cnt != '0), item: r_mem[r_rp]};
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_push.item;
    end

endmodule

`default_nettype wire

// ===== rtl/rri_back.sv =====
// back: pipelined offset division, hit point, saturation and edge test
// depends on rri_pkg
`default_nettype none

module rri_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rri_pkg::t_push                i_head,
    output logic                               o_take,
    input  wire logic [rri_pkg::VecW-1:0]      i_corner,
    input  wire logic [2:0][rri_pkg::CrossW-1:0] i_vn,
    input  wire logic [2:0][rri_pkg::CrossW-1:0] i_nu,
    input  wire logic [rri_pkg::WideW-1:0]     i_det,
    input  wire logic                          i_ready,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic [rri_pkg::VecW-1:0]           o_point
);

    localparam int Q = rri_pkg::QuotBits;
    localparam logic [Q-1:0] Cap = Q'(1) << (rri_pkg::CoordW + 1);
    localparam logic signed [rri_pkg::HitW-1:0] HiV =
        rri_pkg::HitW'((1 << (rri_pkg::CoordW - 1)) - 1);
    localparam logic signed [rri_pkg::HitW-1:0] LoV = -HiV - 1;

    logic en;

    // first stage: offset products
    logic                              r_b0_v;
    logic signed [rri_pkg::CoordW-1:0] r_b0_s [3];
    logic                              r_b0_neg [3];
    logic                              r_b0_rej;
    logic [rri_pkg::MagW-1:0]          r_b0_aden;
    logic [rri_pkg::ProdW-1:0]         r_b0_p [3];

    // divider stages, index 0 holds the rounded dividend
    logic                              r_v    [Q+1];
    logic signed [rri_pkg::CoordW-1:0] r_s    [Q+1][3];
    logic                              r_neg  [Q+1][3];
    logic                              r_ovf  [Q+1][3];
    logic [rri_pkg::RemW-1:0]          r_rem  [Q+1][3];
    logic [Q-1:0]                      r_q    [Q+1][3];
    logic                              r_rej  [Q+1];
    logic [rri_pkg::MagW-1:0]          r_aden [Q+1];

    logic [rri_pkg::RemW-1:0]          n_rem  [Q+1][3];
    logic [Q-1:0]                      n_q    [Q+1][3];
    logic [rri_pkg::RemW-1:0]          n_x    [3];

    logic                              r_h_v;
    logic                              r_h_rej;
    logic signed [rri_pkg::CoordW-1:0] r_h_pt [3];
    logic signed [rri_pkg::DiffW-1:0]  r_h_q  [3];

    logic                              r_m_v;
    logic                              r_m_rej;
    logic signed [rri_pkg::CoordW-1:0] r_m_pt [3];
    logic signed [rri_pkg::EdgePW-1:0] r_m_pa [3];
    logic signed [rri_pkg::EdgePW-1:0] r_m_pb [3];

    logic                              r_s_v;
    logic                              r_s_rej;
    logic signed [rri_pkg::CoordW-1:0] r_s_pt [3];
    logic signed [rri_pkg::WideW-1:0]  r_s_an;
    logic signed [rri_pkg::WideW-1:0]  r_s_bn;

    logic                              r_ov;
    logic                              r_hit;
    logic [rri_pkg::VecW-1:0]          r_pt;

    logic [rri_pkg::DiffW-1:0]         dmag [3];
    logic [Q-1:0]                      qt   [3];
    logic signed [rri_pkg::HitW-1:0]   off  [3];
    logic signed [rri_pkg::HitW-1:0]   hs   [3];
    logic signed [rri_pkg::CoordW-1:0] hpt  [3];
    logic signed [rri_pkg::CoordW-1:0] a_k  [3];
    logic signed [rri_pkg::WideW-1:0]  det;
    logic                              det_pos;
    logic                              in_a;
    logic                              in_b;
    logic                              n_hit;

    assign en      = !r_ov || i_ready;
    assign o_take  = en && i_head.valid;
    assign o_valid = r_ov;
    assign o_hit   = r_hit;
    assign o_point = r_pt;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dmag[k] = ($signed(i_head.item.d[k]) < 0) ? -i_head.item.d[k] : i_head.item.d[k];
            a_k[k]  = $signed(i_corner[k*rri_pkg::CoordW +: rri_pkg::CoordW]);
            n_x[k]  = rri_pkg::RemW'(r_b0_p[k]) + rri_pkg::RemW'(r_b0_aden >> 1);
        end
    end

    // one quotient bit per stage, restoring
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rem[0][k] = n_x[k];
            n_q[0][k]   = '0;
        end
        for (int j = 1; j <= Q; j++) begin
            for (int k = 0; k < 3; k++) begin
                n_rem[j][k] = r_rem[j-1][k];
                n_q[j][k]   = r_q[j-1][k];
                if (r_rem[j-1][k] >= (rri_pkg::RemW'(r_aden[j-1]) << (Q - j))) begin
                    n_rem[j][k] = r_rem[j-1][k] - (rri_pkg::RemW'(r_aden[j-1]) << (Q - j));
                    n_q[j][k][Q-j] = 1'b1;
                end
            end
        end
    end

    // cap, sign, add to the start point and saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_ovf[Q][k] || (r_q[Q][k] > Cap)) qt[k] = Cap;
            else qt[k] = r_q[Q][k];
            off[k] = r_neg[Q][k] ? -$signed(rri_pkg::HitW'(qt[k]))
                                 : $signed(rri_pkg::HitW'(qt[k]));
            hs[k]  = rri_pkg::HitW'(r_s[Q][k]) + off[k];
            if (hs[k] > HiV)      hpt[k] = rri_pkg::CoordW'(HiV);
            else if (hs[k] < LoV) hpt[k] = rri_pkg::CoordW'(LoV);
            else                  hpt[k] = rri_pkg::CoordW'(hs[k]);
        end
    end

    // both edge coordinates in [0,1] against the signed determinant
    always_comb begin
        det     = $signed(i_det);
        det_pos = det > 0;
        if (det_pos) begin
            in_a = (r_s_an >= 0) && (r_s_an <= det);
            in_b = (r_s_bn >= 0) && (r_s_bn <= det);
        end else begin
            in_a = (r_s_an <= 0) && (r_s_an >= det);
            in_b = (r_s_bn <= 0) && (r_s_bn >= det);
        end
        n_hit = !r_s_rej && (det != '0) && in_a && in_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
            for (int j = 0; j <= Q; j++) r_v[j] <= 1'b0;
            r_h_v  <= 1'b0;
            r_m_v  <= 1'b0;
            r_s_v  <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_b0_v <= i_head.valid;
            r_v[0] <= r_b0_v;
            for (int j = 1; j <= Q; j++) r_v[j] <= r_v[j-1];
            r_h_v  <= r_v[Q];
            r_m_v  <= r_h_v;
            r_s_v  <= r_m_v;
            r_ov   <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_b0_s[k]   <= $signed(i_head.item.s[k]);
                r_b0_neg[k] <= i_head.item.d[k][rri_pkg::DiffW-1];
                r_b0_p[k]   <= i_head.item.anum * dmag[k];
            end
            r_b0_rej  <= i_head.item.rej;
            r_b0_aden <= i_head.item.aden;

            for (int k = 0; k < 3; k++) begin
                r_s[0][k]   <= r_b0_s[k];
                r_neg[0][k] <= r_b0_neg[k];
                r_ovf[0][k] <= n_x[k] >= (rri_pkg::RemW'(r_b0_aden) << Q);
                r_rem[0][k] <= n_rem[0][k];
                r_q[0][k]   <= n_q[0][k];
            end
            r_rej[0]  <= r_b0_rej;
            r_aden[0] <= r_b0_aden;
            for (int j = 1; j <= Q; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_s[j][k]   <= r_s[j-1][k];
                    r_neg[j][k] <= r_neg[j-1][k];
                    r_ovf[j][k] <= r_ovf[j-1][k];
                    r_rem[j][k] <= n_rem[j][k];
                    r_q[j][k]   <= n_q[j][k];
                end
                r_rej[j]  <= r_rej[j-1];
                r_aden[j] <= r_aden[j-1];
            end

            r_h_rej <= r_rej[Q];
            for (int k = 0; k < 3; k++) begin
                r_h_pt[k] <= hpt[k];
                r_h_q[k]  <= rri_pkg::DiffW'(hpt[k]) - rri_pkg::DiffW'(a_k[k]);
            end

            r_m_rej <= r_h_rej;
            for (int k = 0; k < 3; k++) begin
                r_m_pt[k] <= r_h_pt[k];
                r_m_pa[k] <= r_h_q[k] * $signed(i_vn[k]);
                r_m_pb[k] <= r_h_q[k] * $signed(i_nu[k]);
            end

            r_s_rej <= r_m_rej;
            for (int k = 0; k < 3; k++) r_s_pt[k] <= r_m_pt[k];
            r_s_an <= rri_pkg::WideW'(r_m_pa[0]) + rri_pkg::WideW'(r_m_pa[1])
                    + rri_pkg::WideW'(r_m_pa[2]);
            r_s_bn <= rri_pkg::WideW'(r_m_pb[0]) + rri_pkg::WideW'(r_m_pb[1])
                    + rri_pkg::WideW'(r_m_pb[2]);

            r_hit <= n_hit;
            for (int k = 0; k < 3; k++) begin
                r_pt[k*rri_pkg::CoordW +: rri_pkg::CoordW] <= n_hit ? r_s_pt[k] : '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rri_checker.sv =====
// port-level checks for ray_rectangle_intersect, bound to the top level
// depends on rri_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rri_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tready,
    input wire logic [rri_pkg::VecW-1:0]      m_axis_tdata,
    input wire logic [0:0]                    m_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready
);

    // nothing leaves the block right after reset
    `RRI_ASSERT_ALWAYS(a_rst_no_out, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // the front is open right after reset
    `RRI_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> s_axis_tready)

    // a stalled result holds
    `RRI_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // a miss carries a zero point
    `RRI_ASSERT(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)

endmodule

bind ray_rectangle_intersect rri_checker u_rri_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking bench for ray_rectangle_intersect: directed, random and backpressure rays
// carries its own intersection predictor; depends on rri_pkg and the block rtl
`default_nettype none

module tb_top;

    localparam int  RunLimit = 400000;
    localparam int  DrainCyc = 40;
    localparam int  MaxShown = 10;

    typedef struct packed {
        logic        hit;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_hit;

    logic                           i_clk;
    logic                           i_rst_n;
    logic [6*rri_pkg::CoordW-1:0]   s_axis_tdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [rri_pkg::VecW-1:0]       m_axis_tdata;
    logic [0:0]                     m_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic                           i_cfg_we;
    logic [rri_pkg::CfgIdxW-1:0]    i_cfg_idx;
    logic [rri_pkg::CfgW-1:0]       i_cfg_data;

    // register copies used by the predictor
    logic [47:0] corner_r, edge_u_r, edge_v_r, normal_r;
    logic [15:0] thresh_r;

    t_hit  pending_hits[$];
    int    mismatches, rays_sent, results_seen, hits_seen, cycles;
    bit    no_idle;
    int    hold_left;

    ray_rectangle_intersect uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_hit trace_ray(logic [95:0] r);
        longint a[3], u[3], v[3], n[3], s[3], d[3], h[3], q[3], vn[3], nu[3];
        longint denom, num, aden, anum, qt, off, dets, an, bn;
        t_hit res;
        res = '0;
        denom = 0;
        num = 0;
        for (int k = 0; k < 3; k++) begin
            a[k] = $signed(corner_r[16*k +: 16]);
            u[k] = $signed(edge_u_r[16*k +: 16]);
            v[k] = $signed(edge_v_r[16*k +: 16]);
            n[k] = $signed(normal_r[16*k +: 16]);
            s[k] = $signed(r[16*k +: 16]);
            d[k] = longint'($signed(r[16*(k+3) +: 16])) - s[k];
            denom += n[k] * d[k];
            num += n[k] * (a[k] - s[k]);
        end
        aden = absl(denom);
        if (denom == 0 || aden < (longint'(thresh_r) << rri_pkg::FracBits))
            return res;
        // hit would lie behind the start point
        if (num != 0 && ((num < 0) != (denom < 0)))
            return res;
        anum = absl(num);
        for (int k = 0; k < 3; k++) begin
            qt = (anum * absl(d[k]) + aden / 2) / aden;
            if (qt > (longint'(1) << 17)) qt = longint'(1) << 17;
            off = d[k] < 0 ? -qt : qt;
            h[k] = s[k] + off;
            if (h[k] > 32767) h[k] = 32767;
            if (h[k] < -32768) h[k] = -32768;
            q[k] = h[k] - a[k];
        end
        vn[0] = v[1]*n[2] - v[2]*n[1];
        vn[1] = v[2]*n[0] - v[0]*n[2];
        vn[2] = v[0]*n[1] - v[1]*n[0];
        nu[0] = n[1]*u[2] - n[2]*u[1];
        nu[1] = n[2]*u[0] - n[0]*u[2];
        nu[2] = n[0]*u[1] - n[1]*u[0];
        dets = u[0]*vn[0] + u[1]*vn[1] + u[2]*vn[2];
        if (dets == 0)
            return res;
        an = q[0]*vn[0] + q[1]*vn[1] + q[2]*vn[2];
        bn = q[0]*nu[0] + q[1]*nu[1] + q[2]*nu[2];
        if (dets > 0) begin
            if (an < 0 || an > dets || bn < 0 || bn > dets) return res;
        end else begin
            if (an > 0 || an < dets || bn > 0 || bn < dets) return res;
        end
        res.hit = 1'b1;
        res.x = h[0][15:0];
        res.y = h[1][15:0];
        res.z = h[2][15:0];
        return res;
    endfunction

    function automatic logic [47:0] vec3(int x, int y, int z);
        logic [15:0] px, py, pz;
        px = x[15:0];
        py = y[15:0];
        pz = z[15:0];
        return {pz, py, px};
    endfunction

    function automatic logic [95:0] ray_of(int sx, int sy, int sz, int ex, int ey, int ez);
        return {vec3(ex, ey, ez), vec3(sx, sy, sz)};
    endfunction

    function automatic int clip16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // accepted rays get their expected result queued
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pending_hits.insert(pending_hits.size(), trace_ray(s_axis_tdata));
            rays_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_hit exp_h, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[47:32]};
            results_seen++;
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxShown)
                    $display("unexpected result hit=%0d data=%h", got.hit, m_axis_tdata);
            end else begin
                exp_h = pending_hits.pop_front();
                if (got.hit) hits_seen++;
                if (got !== exp_h) begin
                    mismatches++;
                    if (mismatches <= MaxShown)
                        $display("mismatch: exp hit=%0d x=%h y=%h z=%h, got hit=%0d x=%h y=%h z=%h",
                                 exp_h.hit, exp_h.x, exp_h.y, exp_h.z,
                                 got.hit, got.x, got.y, got.z);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RunLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls per item, plus an occasional long hold
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 7);
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            while (hold_left > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
        end
    end

    task automatic send_ray(logic [95:0] r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= r;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DrainCyc) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rri_pkg::CfgIdxW-1:0] idx, logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            rri_pkg::CfgCorner: corner_r = val;
            rri_pkg::CfgEdgeU:  edge_u_r = val;
            rri_pkg::CfgEdgeV:  edge_v_r = val;
            rri_pkg::CfgNormal: normal_r = val;
            rri_pkg::CfgThresh: thresh_r = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_plate(logic [47:0] c, logic [47:0] u, logic [47:0] v,
                             logic [47:0] n, logic [15:0] thr);
        wait_idle();
        write_reg(rri_pkg::CfgCorner, c);
        write_reg(rri_pkg::CfgEdgeU, u);
        write_reg(rri_pkg::CfgEdgeV, v);
        write_reg(rri_pkg::CfgNormal, n);
        write_reg(rri_pkg::CfgThresh, {32'd0, thr});
    endtask

    function automatic logic [95:0] noise_ray();
        return {$urandom, $urandom, $urandom};
    endfunction

    // ray from above the plane z=0 of the square plate to a point on or below it
    function automatic logic [95:0] square_ray();
        return ray_of($urandom_range(0, 6000) - 3000, $urandom_range(0, 6000) - 3000,
                      $urandom_range(1, 9000),
                      $urandom_range(0, 6000) - 3000, $urandom_range(0, 6000) - 3000,
                      -$urandom_range(0, 9000));
    endfunction

    task automatic test_reset_defaults();
        // zero normal after reset: every ray misses
        repeat (20) send_ray(noise_ray());
        end_burst();
    endtask

    task automatic test_directed();
        set_plate(vec3(-1024, -1024, 0), vec3(2048, 0, 0), vec3(0, 2048, 0),
                  vec3(0, 0, 1024), 16'd1);
        send_ray(ray_of(0, 0, 1024, 0, 0, -1024));             // center hit
        send_ray(ray_of(-1024, -1024, 512, -1024, -1024, 0));  // on the corner
        send_ray(ray_of(1024, 1024, 512, 1024, 1024, -10));    // opposite corner
        send_ray(ray_of(1025, 0, 512, 1025, 0, -512));         // just outside
        send_ray(ray_of(-1025, 0, 512, -1025, 0, -512));
        send_ray(ray_of(100, 200, 0, 300, 400, 700));          // start on the plane
        send_ray(ray_of(0, 0, 1024, 0, 0, 2048));              // pointing away
        send_ray(ray_of(0, 0, -1024, 0, 0, -2048));            // below, away
        send_ray(ray_of(0, 0, 512, 900, 0, 512));              // parallel
        send_ray(ray_of(5, 5, 5, 5, 5, 5));                    // degenerate ray
        send_ray(ray_of(32767, 32767, 32767, -32768, -32768, -32768));
        send_ray(ray_of(-32768, -32768, -32768, 32767, 32767, 32767));
        send_ray(ray_of(0, 0, 32767, 0, 0, -32768));
        send_ray(ray_of(32767, -32768, 1024, 32767, -32768, 1023)); // start at the coordinate limits, outside the plate
        send_ray(ray_of(0, 0, 1024, 1000, 0, 1023));
        send_ray(ray_of(0, 0, 1, 0, 0, 0));                    // tiny step, exact hit
        send_ray(ray_of(0, 0, 1, 3, 0, 0));
        end_burst();
        // near parallel against a large threshold, then threshold zero
        set_plate(vec3(-1024, -1024, 0), vec3(2048, 0, 0), vec3(0, 2048, 0),
                  vec3(0, 0, 1024), 16'd2);
        send_ray(ray_of(0, 0, 1024, 0, 0, -1));                // |denom| far above
        send_ray(ray_of(0, 0, 1024, 0, 0, 1023));              // below threshold
        send_ray(ray_of(0, 0, 1024, 0, 0, 1022));              // equal to threshold
        end_burst();
        set_plate(vec3(-1024, -1024, 0), vec3(2048, 0, 0), vec3(0, 2048, 0),
                  vec3(0, 0, 1024), 16'd0);
        send_ray(ray_of(0, 0, 1024, 0, 0, 1023));
        send_ray(ray_of(0, 0, 512, 900, 0, 512));              // zero denom, zero threshold
        end_burst();
        // flat plate: zero determinant
        set_plate(vec3(0, 0, 0), vec3(2048, 0, 0), vec3(4096, 0, 0),
                  vec3(0, 0, 1024), 16'd1);
        send_ray(ray_of(0, 0, 1024, 0, 0, -1024));
        end_burst();
    endtask

    task automatic test_square_rays(int cnt, int thr);
        set_plate(vec3(-1024, -1024, 0), vec3(2048, 0, 0), vec3(0, 2048, 0),
                  vec3(0, 0, 1024), thr[15:0]);
        for (int i = 0; i < cnt; i++) begin
            no_idle = (i / 60) % 3 == 2;
            send_ray(($urandom_range(0, 9) == 0) ? noise_ray() : square_ray());
        end
        no_idle = 0;
        end_burst();
    endtask

    // random plate in general orientation, rays aimed through it or just past its edges
    task automatic test_tilted(int cnt);
        int u[3], v[3], n[3], c[3], p[3], e[3], ta, tb, h;
        for (int k = 0; k < 3; k++) begin
            u[k] = $urandom_range(0, 4096) - 2048;
            v[k] = $urandom_range(0, 4096) - 2048;
            c[k] = $urandom_range(0, 8192) - 4096;
        end
        n[0] = (u[1]*v[2] - u[2]*v[1]) >>> 11;
        n[1] = (u[2]*v[0] - u[0]*v[2]) >>> 11;
        n[2] = (u[0]*v[1] - u[1]*v[0]) >>> 11;
        set_plate(vec3(c[0], c[1], c[2]), vec3(u[0], u[1], u[2]), vec3(v[0], v[1], v[2]),
                  vec3(n[0], n[1], n[2]), 16'($urandom_range(0, 3)));
        for (int i = 0; i < cnt; i++) begin
            ta = $urandom_range(0, 1200) - 100;
            tb = $urandom_range(0, 1200) - 100;
            h = $urandom_range(0, 2048) + 64;
            for (int k = 0; k < 3; k++) begin
                p[k] = c[k] + (ta * u[k] + tb * v[k]) / 1024;
                e[k] = clip16(p[k] - (n[k] * h) / 1024);
                p[k] = clip16(p[k] + (n[k] * h) / 1024);
            end
            if ($urandom_range(0, 1)) send_ray(ray_of(p[0], p[1], p[2], e[0], e[1], e[2]));
            else send_ray(ray_of(e[0], e[1], e[2], p[0], p[1], p[2]));
        end
        end_burst();
    endtask

    // extreme and random register patterns with random rays
    task automatic test_wild_config(int cnt);
        logic [47:0] patt[4];
        patt[0] = 48'hFFFF_FFFF_FFFF;
        patt[1] = 48'h8000_8000_8000;
        patt[2] = 48'h7FFF_7FFF_7FFF;
        patt[3] = rand48();
        set_plate(patt[$urandom_range(0, 3)], patt[$urandom_range(0, 3)],
                  rand48(), patt[$urandom_range(0, 3)], 16'hFFFF);
        for (int i = 0; i < cnt / 2; i++) send_ray(noise_ray());
        end_burst();
        set_plate(rand48(), rand48(), rand48(), rand48(), 16'($urandom_range(0, 65535)));
        for (int i = 0; i < cnt / 2; i++) send_ray(noise_ray());
        end_burst();
    endtask

    task automatic test_backpressure(int cnt);
        set_plate(vec3(-1024, -1024, 0), vec3(2048, 0, 0), vec3(0, 2048, 0),
                  vec3(0, 0, 1024), 16'd1);
        hold_left = 300;
        no_idle = 1;
        for (int i = 0; i < cnt; i++) send_ray(square_ray());
        no_idle = 0;
        end_burst();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = rri_pkg::CfgCorner;
        i_cfg_data = '0;
        corner_r = '0;
        edge_u_r = '0;
        edge_v_r = '0;
        normal_r = '0;
        thresh_r = 16'd1;
        no_idle = 0;
        hold_left = 0;
        mismatches = 0;
        rays_sent = 0;
        results_seen = 0;
        hits_seen = 0;
        cycles = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_directed();
        test_square_rays(450, 1);
        test_tilted(150);
        test_tilted(150);
        test_tilted(150);
        test_wild_config(200);
        test_square_rays(100, 0);
        test_backpressure(150);
        wait_idle();

        $display("rays sent %0d, results checked %0d, hits %0d", rays_sent, results_seen,
                 hits_seen);
        $display("covered reset state, edge and corner cases, tilted plates, wild registers, backpressure");
        if (mismatches == 0 && pending_hits.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_hits.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
